/* sv/http_byte_range_parser_assert.svh */
// Assertion macros used by the port-level checker of the byte range parser.
`ifndef HTTP_BYTE_RANGE_PARSER_ASSERT_SVH
`define HTTP_BYTE_RANGE_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hbrp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HBRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hbrp assertion failed");

`endif

/* sv/hbrp_pkg.sv */
// Constants and helpers shared by the byte range parser files.
package hbrp_pkg;

  // Width of the position fields on the result port.
  localparam int POS_W = 48;

  // Result status codes.
  localparam logic [1:0] ST_SET     = 2'd0;
  localparam logic [1:0] ST_MULTI   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // The prefix "bytes=" is matched one character per word.
  localparam int PFX_IDX_W = 3;
  localparam logic [PFX_IDX_W-1:0] PFX_LAST = 3'd5;

  function automatic logic [7:0] prefix_byte(logic [PFX_IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h62;  // b
      3'd1:    c = 8'h79;  // y
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h65;  // e
      3'd4:    c = 8'h73;  // s
      3'd5:    c = 8'h3D;  // =
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* sv/hbrp_dec_acc.sv */
// Decimal accumulator step: acc * 10 + digit with an overflow flag.
module hbrp_dec_acc #(
  parameter int VALUE_BITS = 48
) (
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [3:0]            digit_i,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic                  ovf_o
);

  localparam int WideW = VALUE_BITS + 4;

  logic [WideW-1:0] acc_wide;
  logic [WideW-1:0] sum;

  // Times ten as (x << 3) + (x << 1); the result always fits in four extra bits.
  assign acc_wide = WideW'(acc_i);
  assign sum      = (acc_wide << 3) + (acc_wide << 1) + WideW'(digit_i);
  assign acc_o    = sum[VALUE_BITS-1:0];
  assign ovf_o    = |sum[WideW-1:VALUE_BITS];

endmodule

/* sv/http_byte_range_parser.sv */
// Top level of the HTTP Range header value parser.
//
//   channel   direction   handshake                  payload
//   input     in          in_valid_i / in_ready_o    ch_i, first_i
//   result    out         out_valid_o / out_ready_i  status_o, first_pos_o, start_given_o,
//                                                    last_pos_o, end_given_o
//
// One word is accepted per cycle while no stalled result holds the parse stage. A
// word accepted sits in the input register and is parsed there; its result, if any,
// is loaded into the result register and offered on the port from there. The parse
// step with its multiply-by-ten add is combinational. Reset leaves the parser idle,
// waiting for a word with first_i set. A stalled result holds the parse stage, and
// the input register then holds its word as well.
module http_byte_range_parser #(
  parameter int VALUE_BITS = 48
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                ch_i,
  input  logic                      first_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [hbrp_pkg::POS_W-1:0] first_pos_o,
  output logic                      start_given_o,
  output logic [hbrp_pkg::POS_W-1:0] last_pos_o,
  output logic                      end_given_o
);

  import hbrp_pkg::*;

  localparam int PosW = (VALUE_BITS > POS_W) ? VALUE_BITS : POS_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_START,
    PH_END,
    PH_SPACES
  } phase_e;

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_ch_q;
  logic       s1_first_q;
  logic       s1_adv;

  // Parser state.
  phase_e                phase_q, phase_d;
  logic [PFX_IDX_W-1:0]  idx_q, idx_d;
  logic [VALUE_BITS-1:0] sacc_q, sacc_d;
  logic [VALUE_BITS-1:0] eacc_q, eacc_d;
  logic                  sseen_q, sseen_d;
  logic                  eseen_q, eseen_d;

  // Result register.
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [POS_W-1:0]  first_pos_q;
  logic              start_given_q;
  logic [POS_W-1:0]  last_pos_q;
  logic              end_given_q;

  // Parse step signals.
  phase_e                cur_phase;
  logic [PFX_IDX_W-1:0]  cur_idx;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [VALUE_BITS-1:0] sacc_next, eacc_next;
  logic                  sacc_ovf, eacc_ovf;
  logic                  emit;
  logic [1:0]            emit_status;
  logic [PosW-1:0]       sacc_wide, eacc_wide;

  // The parse stage moves on whenever the result register can take a word.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_ch_q    <= '0;
      s1_first_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_ch_q    <= ch_i;
      s1_first_q <= first_i;
    end
  end

  // Digit decode.
  assign is_digit = (s1_ch_q >= CH_ZERO) && (s1_ch_q <= CH_NINE);
  assign digit    = 4'(s1_ch_q - CH_ZERO);

  hbrp_dec_acc #(.VALUE_BITS(VALUE_BITS)) u_start_acc (
    .acc_i   (sacc_q),
    .digit_i (digit),
    .acc_o   (sacc_next),
    .ovf_o   (sacc_ovf)
  );

  hbrp_dec_acc #(.VALUE_BITS(VALUE_BITS)) u_end_acc (
    .acc_i   (eacc_q),
    .digit_i (digit),
    .acc_o   (eacc_next),
    .ovf_o   (eacc_ovf)
  );

  // One parse step for the word in the input register.
  always_comb begin
    cur_phase   = s1_first_q ? PH_PREFIX : phase_q;
    cur_idx     = s1_first_q ? '0 : idx_q;
    phase_d     = cur_phase;
    idx_d       = cur_idx;
    sacc_d      = s1_first_q ? '0 : sacc_q;
    eacc_d      = s1_first_q ? '0 : eacc_q;
    sseen_d     = s1_first_q ? 1'b0 : sseen_q;
    eseen_d     = s1_first_q ? 1'b0 : eseen_q;
    emit        = 1'b0;
    emit_status = ST_INVALID;

    case (cur_phase)
      PH_PREFIX: begin
        if (s1_ch_q != prefix_byte(cur_idx)) begin
          emit = 1'b1;
        end else if (cur_idx == PFX_LAST) begin
          phase_d = PH_START;
        end else begin
          idx_d = cur_idx + 1'b1;
        end
      end
      PH_START: begin
        if (is_digit) begin
          if (sacc_ovf) begin
            emit = 1'b1;
          end else begin
            sacc_d  = sacc_next;
            sseen_d = 1'b1;
          end
        end else if (s1_ch_q == CH_DASH) begin
          phase_d = PH_END;
        end else begin
          emit = 1'b1;
        end
      end
      PH_END, PH_SPACES: begin
        if ((cur_phase == PH_END) && is_digit) begin
          if (eacc_ovf) begin
            emit = 1'b1;
          end else begin
            eacc_d  = eacc_next;
            eseen_d = 1'b1;
          end
        end else if ((cur_phase == PH_END) && !sseen_q && !eseen_q) begin
          // Neither number was given.
          emit = 1'b1;
        end else if ((cur_phase == PH_END) && sseen_q && eseen_q && (sacc_q > eacc_q)) begin
          // Start lies past the end.
          emit = 1'b1;
        end else if (s1_ch_q == CH_SPACE) begin
          phase_d = PH_SPACES;
        end else if (s1_ch_q == CH_COMMA) begin
          emit        = 1'b1;
          emit_status = ST_MULTI;
        end else if (s1_ch_q == CH_CR) begin
          emit        = 1'b1;
          emit_status = ST_SET;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (emit) begin
      phase_d = PH_IDLE;
    end
  end

  // Positions are widened or cut to the port width.
  assign sacc_wide = PosW'(sacc_q);
  assign eacc_wide = PosW'(eacc_q);

  // Parser state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      idx_q         <= '0;
      sacc_q        <= '0;
      eacc_q        <= '0;
      sseen_q       <= 1'b0;
      eseen_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      status_q      <= ST_SET;
      first_pos_q   <= '0;
      start_given_q <= 1'b0;
      last_pos_q    <= '0;
      end_given_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        sacc_q  <= sacc_d;
        eacc_q  <= eacc_d;
        sseen_q <= sseen_d;
        eseen_q <= eseen_d;
        if (emit) begin
          out_valid_q <= 1'b1;
          status_q    <= emit_status;
          if (emit_status == ST_SET) begin
            first_pos_q   <= sseen_q ? sacc_wide[POS_W-1:0] : '0;
            start_given_q <= sseen_q;
            last_pos_q    <= eseen_q ? eacc_wide[POS_W-1:0] : '0;
            end_given_q   <= eseen_q;
          end else begin
            first_pos_q   <= '0;
            start_given_q <= 1'b0;
            last_pos_q    <= '0;
            end_given_q   <= 1'b0;
          end
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign first_pos_o   = first_pos_q;
  assign start_given_o = start_given_q;
  assign last_pos_o    = last_pos_q;
  assign end_given_o   = end_given_q;

endmodule

/* sv/hbrp_checker.sv */
// Port-level checker for the byte range parser and its bind.
`include "http_byte_range_parser_assert.svh"

module hbrp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 status_o,
  input logic [hbrp_pkg::POS_W-1:0] first_pos_o,
  input logic                       start_given_o,
  input logic [hbrp_pkg::POS_W-1:0] last_pos_o,
  input logic                       end_given_o
);

  import hbrp_pkg::*;

  // A stalled result stays on the port with its status and positions unchanged.
  `HBRP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(first_pos_o) && $stable(last_pos_o))

  // Only the three defined status codes appear.
  `HBRP_ASSERT_NOW(a_status_code, out_valid_o, status_o == ST_SET || status_o == ST_MULTI || status_o == ST_INVALID)

  // Results other than a set range carry no positions.
  `HBRP_ASSERT_NOW(a_unset_zero, out_valid_o && status_o != ST_SET, !start_given_o && !end_given_o && first_pos_o == '0 && last_pos_o == '0)

  // A missing number reads as zero.
  `HBRP_ASSERT_NOW(a_absent_zero, out_valid_o, (start_given_o || first_pos_o == '0) && (end_given_o || last_pos_o == '0))

endmodule

bind http_byte_range_parser hbrp_checker u_hbrp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .first_pos_o   (first_pos_o),
  .start_given_o (start_given_o),
  .last_pos_o    (last_pos_o),
  .end_given_o   (end_given_o)
);

/* dv/range_result_checker.sv */
// Checker that predicts the byte range parser's results and compares them.
module range_result_checker #(
  parameter int VALUE_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [7:0]                 ch_i,
  input  logic                       first_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [1:0]                 status_i,
  input  logic [hbrp_pkg::POS_W-1:0] first_pos_i,
  input  logic                       start_given_i,
  input  logic [hbrp_pkg::POS_W-1:0] last_pos_i,
  input  logic                       end_given_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         set_count_o,
  output int                         multi_count_o,
  output int                         invalid_count_o
);
  import hbrp_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] first_pos;
    logic             start_given;
    logic [POS_W-1:0] last_pos;
    logic             end_given;
  } range_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_START,
    PH_END,
    PH_SPACES
  } parse_phase_e;

  localparam logic [47:0] PREFIX_TEXT = "bytes=";
  localparam logic [63:0] NUM_MAX = (64'd1 << VALUE_BITS) - 64'd1;

  // Own copy of the parser state.
  parse_phase_e phase;
  logic [2:0]   pfx_idx;
  logic [63:0]  start_val;
  logic [63:0]  end_val;
  logic         start_seen;
  logic         end_seen;

  range_t expected_ranges[$];
  range_t want;
  range_t got;
  range_t pred;
  bit     emitted;

  task automatic clear_parser();
    phase = PH_IDLE;
    pfx_idx = '0;
    start_val = '0;
    end_val = '0;
    start_seen = 1'b0;
    end_seen = 1'b0;
  endtask

  // Fields other than the status are only filled in for a range that was set.
  function automatic range_t make_result(input logic [1:0] st);
    range_t r;
    r = '0;
    r.status = st;
    if (st == ST_SET) begin
      r.start_given = start_seen;
      r.end_given = end_seen;
      if (start_seen) r.first_pos = start_val[POS_W-1:0];
      if (end_seen) r.last_pos = end_val[POS_W-1:0];
    end
    return r;
  endfunction

  // A further digit is only taken if the number still fits in VALUE_BITS bits.
  function automatic bit digit_fits(input logic [63:0] acc, input logic [63:0] d);
    return acc <= (NUM_MAX - d) / 64'd10;
  endfunction

  // Advances the predicted parser by one word and tells whether it gives a result.
  task automatic step_parser(input logic [7:0] c, input logic f, output bit has_result,
                             output range_t r);
    bit         is_digit;
    bit         at_tail;
    logic [1:0] st;
    logic [63:0] d;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 64'(c - CH_ZERO);
    at_tail = 1'b0;
    has_result = 1'b0;
    st = ST_INVALID;
    r = '0;
    if (f) begin
      clear_parser();
      phase = PH_PREFIX;
    end
    case (phase)
      PH_PREFIX: begin
        if (c != PREFIX_TEXT[8 * (5 - int'(pfx_idx)) +: 8]) begin
          has_result = 1'b1;
        end else if (pfx_idx == 3'd5) begin
          phase = PH_START;
        end else begin
          pfx_idx = pfx_idx + 3'd1;
        end
      end
      PH_START: begin
        if (is_digit) begin
          if (digit_fits(start_val, d)) begin
            start_val = start_val * 64'd10 + d;
            start_seen = 1'b1;
          end else begin
            has_result = 1'b1;
          end
        end else if (c == CH_DASH) begin
          phase = PH_END;
        end else begin
          has_result = 1'b1;
        end
      end
      PH_END: begin
        if (is_digit) begin
          if (digit_fits(end_val, d)) begin
            end_val = end_val * 64'd10 + d;
            end_seen = 1'b1;
          end else begin
            has_result = 1'b1;
          end
        end else if (!start_seen && !end_seen) begin
          has_result = 1'b1;
        end else if (start_seen && end_seen && start_val > end_val) begin
          has_result = 1'b1;
        end else begin
          at_tail = 1'b1;
        end
      end
      PH_SPACES: at_tail = 1'b1;
      default: ;
    endcase
    // After the numbers: spaces are skipped, then the terminator decides.
    if (at_tail) begin
      if (c == CH_SPACE) begin
        phase = PH_SPACES;
      end else begin
        has_result = 1'b1;
        if (c == CH_COMMA) st = ST_MULTI;
        else if (c == CH_CR) st = ST_SET;
        else st = ST_INVALID;
      end
    end
    if (has_result) begin
      r = make_result(st);
      phase = PH_IDLE;
    end
  endtask

  task automatic report_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    set_count_o = 0;
    multi_count_o = 0;
    invalid_count_o = 0;
    clear_parser();
  end

  // Compare the result word first; a word accepted now cannot have its result yet.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      expected_ranges.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.status = status_i;
        got.first_pos = first_pos_i;
        got.start_given = start_given_i;
        got.last_pos = last_pos_i;
        got.end_given = end_given_i;
        if (expected_ranges.size() == 0) begin
          $display("%0t: result with no word waiting for it: expected none, actual status %0d",
                   $time, status_i);
          fail_count_o++;
        end else begin
          want = expected_ranges.pop_front();
          report_field("status", 64'(want.status), 64'(got.status));
          report_field("first_pos", 64'(want.first_pos), 64'(got.first_pos));
          report_field("start_given", 64'(want.start_given), 64'(got.start_given));
          report_field("last_pos", 64'(want.last_pos), 64'(got.last_pos));
          report_field("end_given", 64'(want.end_given), 64'(got.end_given));
          if (want.status == ST_SET) set_count_o++;
          else if (want.status == ST_MULTI) multi_count_o++;
          else invalid_count_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_parser(ch_i, first_i, emitted, pred);
        if (emitted) expected_ranges.push_back(pred);
      end
      pending_o <= expected_ranges.size();
    end
  end

endmodule

/* dv/testbench.sv */
// Top of the byte range parser testbench: stimulus, result-side stalls and verdict.
module testbench;
  import hbrp_pkg::*;

  localparam int VALUE_BITS = 48;
  localparam int WORD_TARGET = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int END_CYCLES = 8;
  localparam logic [63:0] VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           ch = 8'h00;
  logic                 first = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [POS_W-1:0]     first_pos;
  logic                 start_given;
  logic [POS_W-1:0]     last_pos;
  logic                 end_given;

  int fail_count;
  int pending;
  int set_count;
  int multi_count;
  int invalid_count;

  int words_sent = 0;
  int values_sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  bit pause_done = 1'b0;
  bit lead;

  logic [7:0] value_q[$];

  http_byte_range_parser #(
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .ch_i         (ch),
    .first_i      (first),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .first_pos_o  (first_pos),
    .start_given_o(start_given),
    .last_pos_o   (last_pos),
    .end_given_o  (end_given)
  );

  range_result_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) range_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .ch_i           (ch),
    .first_i        (first),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .first_pos_i    (first_pos),
    .start_given_i  (start_given),
    .last_pos_i     (last_pos),
    .end_given_i    (end_given),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .set_count_o    (set_count),
    .multi_count_o  (multi_count),
    .invalid_count_o(invalid_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offers one word, possibly after random idle cycles, and waits until it is taken.
  task automatic send_word(input logic [7:0] c, input logic f);
    while (idle_on && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    first <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_queue(input bit lead_first);
    for (int i = 0; i < value_q.size(); i++) begin
      send_word(value_q[i], lead_first && (i == 0));
    end
    if (lead_first) values_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      value_q.push_back(s.getc(i));
    end
  endtask

  task automatic send_text(input string s, input bit with_cr);
    value_q.delete();
    push_text(s);
    if (with_cr) value_q.push_back(CH_CR);
    send_queue(1'b1);
  endtask

  // Stops offering words until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly small positions; now and then full width, the edge of the range or beyond it.
  function automatic logic [63:0] pick_position();
    logic [63:0] n;
    case ($urandom_range(10))
      0, 1, 2:    n = $urandom_range(0, 9);
      3, 4, 5:    n = $urandom_range(0, 99999);
      6:          n = $urandom;
      7:          n = {$urandom, $urandom} & VALUE_MAX;
      8:          n = VALUE_MAX - $urandom_range(0, 20);
      9:          n = VALUE_MAX + 64'd1 + $urandom_range(0, 30);
      default:    n = {$urandom, $urandom};
    endcase
    return n;
  endfunction

  // Builds a value with random numbers, spacing and terminator; it is not always well-formed.
  task automatic build_value();
    bit          has_start;
    bit          has_end;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] t;
    int          pick;
    value_q.delete();
    push_text("bytes=");
    has_start = $urandom_range(99) < 80;
    has_end = $urandom_range(99) < 80;
    a = pick_position();
    b = pick_position();
    if (has_start && has_end && a > b && $urandom_range(3) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    if (has_start) begin
      if ($urandom_range(7) == 0) push_text("0");
      push_text($sformatf("%0d", a));
    end
    value_q.push_back(CH_DASH);
    if (has_end) push_text($sformatf("%0d", b));
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) value_q.push_back(CH_SPACE);
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      value_q.push_back(CH_CR);
    end else if (pick < 85) begin
      value_q.push_back(CH_COMMA);
      push_text(" 8-9");
      value_q.push_back(CH_CR);
    end else begin
      value_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Broken values, cut-off values and stray words.
  task automatic build_noise(output bit lead_first);
    int         k;
    logic [7:0] dropped;
    lead_first = 1'b1;
    case ($urandom_range(4))
      0: begin
        build_value();
        value_q[$urandom_range(value_q.size() - 1)] = 8'($urandom_range(255));
      end
      1: begin
        build_value();
        k = $urandom_range(1, value_q.size() - 1);
        while (value_q.size() > k) dropped = value_q.pop_back();
      end
      2: begin
        value_q.delete();
        repeat ($urandom_range(1, 6)) value_q.push_back(8'($urandom_range(255)));
        lead_first = 1'b0;
      end
      3: begin
        value_q.delete();
        repeat ($urandom_range(1, 6)) value_q.push_back(8'($urandom_range(255)));
      end
      default: begin
        value_q.delete();
        push_text("bytes=");
        k = $urandom_range(1, 5);
        while (value_q.size() > k) dropped = value_q.pop_back();
        value_q.push_back(CH_CR);
      end
    endcase
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!idle_on || $urandom_range(99) >= 18) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
      end
    end
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: stray words while idle, then the notable shapes of a value.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_text("bytes=0-0", 1'b1);
    send_text("bytes=-5", 1'b1);
    send_text("bytes=7-", 1'b1);
    send_text("bytes=-", 1'b1);
    send_text("bytes=9-3,", 1'b0);
    send_text("bytes=1-2, 3-4", 1'b1);
    send_text("bytes=10-20   ", 1'b1);
    send_text("bytes=1-2 x", 1'b0);
    send_text("Bytes=1-2", 1'b1);
    send_text("byt", 1'b1);
    send_text("bytes=12", 1'b1);
    send_text("bytes=3", 1'b0);
    send_text("bytes=4-5", 1'b1);
    send_text("bytes=281474976710655-281474976710655", 1'b1);
    send_text("bytes=281474976710656-", 1'b1);
    send_text("bytes=0-281474976710656", 1'b1);
    send_text("bytes=007-00009", 1'b1);
    send_text("bytes=5-x", 1'b0);
    send_text("bytes=x", 1'b0);
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b0);
    drain_results();

    // Random part: mostly well-formed values, the rest noise.
    while (words_sent < WORD_TARGET) begin
      idle_on = !(words_sent >= 700 && words_sent < 950);
      if (!hold_done && words_sent >= 400) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && words_sent >= 1200) begin
        drain_results();
        pause_done = 1'b1;
      end
      if ($urandom_range(99) < 75) begin
        build_value();
        lead = 1'b1;
      end else begin
        build_noise(lead);
      end
      send_queue(lead);
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("Summary: %0d words in %0d header values; results checked: %0d set, %0d multi-range, %0d invalid.",
             words_sent, values_sent, set_count, multi_count, invalid_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* http_byte_range_parser.f */
+incdir+sv
sv/hbrp_pkg.sv
sv/hbrp_dec_acc.sv
sv/http_byte_range_parser.sv
sv/hbrp_checker.sv
dv/range_result_checker.sv
dv/testbench.sv
